// ===== rtl/core/necir_pkg.sv =====
// ----------------------------------------------------------------------------
// necir_pkg
// Shared widths, register indexes, reset values and result status codes for
// the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Capture clock ticks per 10 us; a power of two keeps the scaling a shift
  localparam int TICKS_PER_10US = 8;

  // Field widths
  localparam int DUR_W   = 15;
  localparam int CFG_W   = 16;
  localparam int HTOL_W  = 12;
  localparam int BTOL_W  = 10;
  localparam int IDX_W   = 6;
  localparam int CIDX_W  = 3;

  // Duration scaling: ticks * 10 / TICKS_PER_10US
  localparam int DUR_MAX = (1 << DUR_W) - 1;
  localparam int PROD_W  = $clog2(DUR_MAX * 10 + 1);
  localparam int US_W    = $clog2((DUR_MAX * 10) / TICKS_PER_10US + 1);

  // Width that holds the sum of an expected value and a tolerance, or a
  // converted duration, with one spare bit
  localparam int CMP_W   = ((US_W > CFG_W) ? US_W : CFG_W) + 1;

  // Last item index before saturation
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_HEADER_TOL    = 3'd2,
    REG_BIT_MARK      = 3'd3,
    REG_ZERO_SPACE    = 3'd4,
    REG_ONE_SPACE     = 3'd5,
    REG_BIT_TOL       = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers, in microseconds
  localparam logic [CFG_W-1:0]  RST_HEADER_FIRST  = 16'd9000;
  localparam logic [CFG_W-1:0]  RST_HEADER_SECOND = 16'd4500;
  localparam logic [HTOL_W-1:0] RST_HEADER_TOL    = 12'd200;
  localparam logic [CFG_W-1:0]  RST_BIT_MARK      = 16'd560;
  localparam logic [CFG_W-1:0]  RST_ZERO_SPACE    = 16'd560;
  localparam logic [CFG_W-1:0]  RST_ONE_SPACE     = 16'd1690;
  localparam logic [BTOL_W-1:0] RST_BIT_TOL       = 10'd100;

  // Item indexes at which a completed byte is latched
  localparam logic [IDX_W-1:0] IDX_ADDR     = 6'd8;
  localparam logic [IDX_W-1:0] IDX_INV_ADDR = 6'd16;
  localparam logic [IDX_W-1:0] IDX_CMD      = 6'd24;
  localparam logic [IDX_W-1:0] IDX_INV_CMD  = 6'd32;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_FRAME = 2'd1,
    STATUS_MISMATCH = 2'd2
  } status_t;

endpackage

// ===== rtl/core/nec_ir_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_unit
// Decodes NEC infrared frames from captured pulse items: header check, bit
// classification, byte capture and complement check, one result per frame.
// ----------------------------------------------------------------------------
// Throughput: one pulse item per cycle, except while in_stall holds a last
// item; the frame state updates at the edge that accepts the item, through
// one compare-and-shift stage. The result of a frame is valid in the cycle
// after its last item is accepted. A last item waits only while a previous
// result is held under stall. Reset: frame state and result valid clear;
// the timing registers return to their nominal NEC values.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_write,
  input  logic [necir_pkg::CIDX_W-1:0]      cfg_index,
  input  logic [necir_pkg::CFG_W-1:0]       cfg_data,
  // Pulse item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [necir_pkg::DUR_W-1:0]       first_duration,
  input  logic [necir_pkg::DUR_W-1:0]       second_duration,
  input  logic                              last_item,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        address,
  output logic [7:0]                        command,
  output logic [1:0]                        status
);

  localparam int CMP_W = necir_pkg::CMP_W;

  // Timing registers
  logic [necir_pkg::CFG_W-1:0]  header_first_us;
  logic [necir_pkg::CFG_W-1:0]  header_second_us;
  logic [necir_pkg::HTOL_W-1:0] header_tolerance_us;
  logic [necir_pkg::CFG_W-1:0]  bit_mark_us;
  logic [necir_pkg::CFG_W-1:0]  zero_space_us;
  logic [necir_pkg::CFG_W-1:0]  one_space_us;
  logic [necir_pkg::BTOL_W-1:0] bit_tolerance_us;

  // Frame state
  logic [necir_pkg::IDX_W-1:0] item_index, item_index_next;
  logic [2:0]                  bit_count, bit_count_next;
  logic [7:0]                  shift_byte, shift_byte_next;
  logic [7:0]                  addr_byte, addr_byte_next;
  logic [7:0]                  inv_addr_byte, inv_addr_byte_next;
  logic [7:0]                  cmd_byte, cmd_byte_next;
  logic [7:0]                  inv_cmd_byte, inv_cmd_byte_next;
  logic                        header_failed, header_failed_next;

  logic                        in_accept;
  logic                        out_accept;

  logic [necir_pkg::PROD_W-1:0] first_prod, second_prod;
  logic [necir_pkg::US_W-1:0]   first_us, second_us;
  logic                         second_absent;
  logic                         header_match, zero_match, one_match;
  logic [7:0]                   shifted_byte;
  logic                         mismatch;

  // Match v against e within tolerance t: e - t <= v <= e + t
  function automatic logic near_value(input logic [CMP_W-1:0] v,
                                      input logic [CMP_W-1:0] e,
                                      input logic [CMP_W-1:0] t);
    logic [CMP_W:0] v_plus_t;
    logic [CMP_W:0] e_plus_t;
    v_plus_t = {1'b0, v} + {1'b0, t};
    e_plus_t = {1'b0, e} + {1'b0, t};
    return (v_plus_t >= {1'b0, e}) && ({1'b0, v} <= e_plus_t);
  endfunction

  // Handshakes: hold a last item while the previous result is stalled
  assign in_stall   = out_valid && out_stall && last_item;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Convert tick counts to microseconds
  assign first_prod  = necir_pkg::PROD_W'(first_duration) * necir_pkg::PROD_W'(10);
  assign second_prod = necir_pkg::PROD_W'(second_duration) * necir_pkg::PROD_W'(10);
  assign first_us    = necir_pkg::US_W'(first_prod / necir_pkg::TICKS_PER_10US);
  assign second_us   = necir_pkg::US_W'(second_prod / necir_pkg::TICKS_PER_10US);
  assign second_absent = (second_us == '0);

  // Classify the item against header and bit timings
  assign header_match =
    near_value(CMP_W'(first_us), CMP_W'(header_first_us), CMP_W'(header_tolerance_us)) &&
    (second_absent ||
     near_value(CMP_W'(second_us), CMP_W'(header_second_us), CMP_W'(header_tolerance_us)));

  assign zero_match =
    near_value(CMP_W'(first_us), CMP_W'(bit_mark_us), CMP_W'(bit_tolerance_us)) &&
    (second_absent ||
     near_value(CMP_W'(second_us), CMP_W'(zero_space_us), CMP_W'(bit_tolerance_us)));

  assign one_match =
    near_value(CMP_W'(first_us), CMP_W'(bit_mark_us), CMP_W'(bit_tolerance_us)) &&
    (second_absent ||
     near_value(CMP_W'(second_us), CMP_W'(one_space_us), CMP_W'(bit_tolerance_us)));

  // Shift in LSB first; an unknown item leaves the byte as it is
  always_comb begin
    if (zero_match) begin
      shifted_byte = {1'b0, shift_byte[7:1]};
    end else if (one_match) begin
      shifted_byte = {1'b1, shift_byte[7:1]};
    end else begin
      shifted_byte = shift_byte;
    end
  end

  // Next frame state for the current item
  always_comb begin
    header_failed_next = header_failed;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    addr_byte_next     = addr_byte;
    inv_addr_byte_next = inv_addr_byte;
    cmd_byte_next      = cmd_byte;
    inv_cmd_byte_next  = inv_cmd_byte;

    if (item_index == '0) begin
      header_failed_next = !header_match;
    end else if (!header_failed) begin
      if (bit_count == 3'd7) begin
        bit_count_next  = '0;
        shift_byte_next = '0;
        if (item_index == necir_pkg::IDX_ADDR) begin
          addr_byte_next = shifted_byte;
        end else if (item_index == necir_pkg::IDX_INV_ADDR) begin
          inv_addr_byte_next = shifted_byte;
        end else if (item_index == necir_pkg::IDX_CMD) begin
          cmd_byte_next = shifted_byte;
        end else if (item_index == necir_pkg::IDX_INV_CMD) begin
          inv_cmd_byte_next = shifted_byte;
        end
      end else begin
        bit_count_next  = bit_count + 3'd1;
        shift_byte_next = shifted_byte;
      end
    end

    if (item_index != necir_pkg::IDX_MAX) begin
      item_index_next = item_index + 1'b1;
    end else begin
      item_index_next = item_index;
    end
  end

  assign mismatch = (addr_byte_next != ~inv_addr_byte_next) ||
                    (cmd_byte_next != ~inv_cmd_byte_next);

  // Timing registers: write on enable, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first_us     <= necir_pkg::RST_HEADER_FIRST;
      header_second_us    <= necir_pkg::RST_HEADER_SECOND;
      header_tolerance_us <= necir_pkg::RST_HEADER_TOL;
      bit_mark_us         <= necir_pkg::RST_BIT_MARK;
      zero_space_us       <= necir_pkg::RST_ZERO_SPACE;
      one_space_us        <= necir_pkg::RST_ONE_SPACE;
      bit_tolerance_us    <= necir_pkg::RST_BIT_TOL;
    end else if (cfg_write) begin
      case (necir_pkg::cfg_reg_t'(cfg_index))
        necir_pkg::REG_HEADER_FIRST:  header_first_us  <= cfg_data;
        necir_pkg::REG_HEADER_SECOND: header_second_us <= cfg_data;
        necir_pkg::REG_HEADER_TOL:
          header_tolerance_us <= cfg_data[necir_pkg::HTOL_W-1:0];
        necir_pkg::REG_BIT_MARK:      bit_mark_us      <= cfg_data;
        necir_pkg::REG_ZERO_SPACE:    zero_space_us    <= cfg_data;
        necir_pkg::REG_ONE_SPACE:     one_space_us     <= cfg_data;
        necir_pkg::REG_BIT_TOL:
          bit_tolerance_us <= cfg_data[necir_pkg::BTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame state: advance on each transaction, clear after the last item
  always_ff @(posedge clk) begin
    if (rst || (in_accept && last_item)) begin
      item_index    <= '0;
      bit_count     <= '0;
      shift_byte    <= '0;
      addr_byte     <= '0;
      inv_addr_byte <= '0;
      cmd_byte      <= '0;
      inv_cmd_byte  <= '0;
      header_failed <= 1'b0;
    end else if (in_accept) begin
      item_index    <= item_index_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      addr_byte     <= addr_byte_next;
      inv_addr_byte <= inv_addr_byte_next;
      cmd_byte      <= cmd_byte_next;
      inv_cmd_byte  <= inv_cmd_byte_next;
      header_failed <= header_failed_next;
    end
  end

  // Result register: load on the last item, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_item) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_item) begin
      if (header_failed_next) begin
        address <= '0;
        command <= '0;
        status  <= necir_pkg::STATUS_NO_FRAME;
      end else begin
        address <= addr_byte_next;
        command <= cmd_byte_next;
        status  <= mismatch ? necir_pkg::STATUS_MISMATCH : necir_pkg::STATUS_OK;
      end
    end
  end

  // A last item always leaves a pending result and a cleared frame
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_item) |=> (out_valid && item_index == '0))
    else $error("last item did not produce a result or clear the frame");

  // At the start of a frame no bits are pending
  assert property (@(posedge clk) disable iff (rst)
    (item_index == '0) |-> (bit_count == '0 && shift_byte == '0))
    else $error("bit state not clear at frame start");

  // A failed header stops all bit collection
  assert property (@(posedge clk) disable iff (rst)
    header_failed |-> (bit_count == '0 && shift_byte == '0 && addr_byte == '0))
    else $error("bits collected after a failed header");

  // A frame without a header reports no address or command
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == necir_pkg::STATUS_NO_FRAME) |->
      (address == '0 && command == '0))
    else $error("failed frame reports a non-zero address or command");

endmodule
